// ===== sv/page_byte_touch_bitmap_macros.svh =====
// Assertion macros for the page byte touch bitmap RTL.
`ifndef PAGE_BYTE_TOUCH_BITMAP_MACROS_SVH
`define PAGE_BYTE_TOUCH_BITMAP_MACROS_SVH

`ifndef SYNTHESIS

// Check that cons holds in the same cycle as ante.
`define PBTB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("page_byte_touch_bitmap: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define PBTB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("page_byte_touch_bitmap: next-cycle check failed");

`else

`define PBTB_ASSERT_NOW(label, ante, cons)
`define PBTB_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== sv/pbtb_pkg.sv =====
// Shared types, constants and bit functions for the page byte touch bitmap.
package pbtb_pkg;

    localparam int PAGE_BYTES_DEF = 4096;
    localparam int WORD_BITS      = 64;
    localparam int OUT_W          = 13;

    typedef enum logic {
        OP_MARK,
        OP_MERGE
    } op_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RMW,
        ST_SUM
    } state_t;

    // Bits lo..hi inclusive, lo <= hi.
    function automatic logic [WORD_BITS-1:0] range_mask(input logic [5:0] lo,
                                                        input logic [5:0] hi);
        logic [WORD_BITS-1:0] lo_m;
        logic [WORD_BITS-1:0] hi_m;
        lo_m = {WORD_BITS{1'b1}} << lo;
        hi_m = {WORD_BITS{1'b1}} >> (6'd63 - hi);
        return lo_m & hi_m;
    endfunction

    function automatic logic [6:0] popcount64(input logic [WORD_BITS-1:0] v);
        logic [6:0] n;
        n = 7'd0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            n = n + {6'd0, v[i]};
        end
        return n;
    endfunction

endpackage

// ===== sv/page_byte_touch_bitmap.sv =====
// Top level: byte touch bitmap of one page, kept in a read-modify-write word memory.
//
//  channel   | dir | handshake          | payload
//  ----------+-----+--------------------+------------------------------------------------
//  s_        | in  | s_tvalid/s_tready  | tdata: first_byte, last_byte, word_index,
//            |     |                    |        other_word; tuser: op, other_full
//  m_        | out | m_tvalid/m_tready  | tdata: newly_set, touched_total, page_full
//
// Flow: a beat covers W bitmap words (1 for a merge, an empty range or a range inside one
// word): one word is read, ORed and written back per cycle, and a closing state sums the
// count and takes the next beat.
// Reset: a clearing pass zeroes the memory word by word, with s_tready low.
// Stalls: a waiting result does not block the next beat; only the closing cycle holds
// until the previous result is taken.
`include "page_byte_touch_bitmap_macros.svh"

module page_byte_touch_bitmap #(
    parameter int PAGE_BYTES = pbtb_pkg::PAGE_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [11:0] first_byte, [23:12] last_byte, [29:24] word_index, [93:30] other_word,
    // [95:94] zero
    input  logic [95:0] s_tdata,
    // [0] op, [1] other_full
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [12:0] newly_set, [25:13] touched_total, [26] page_full, [31:27] zero
    output logic [31:0] m_tdata
);

    localparam int WORD_COUNT = PAGE_BYTES / pbtb_pkg::WORD_BITS;
    localparam int WORD_AW    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int CNT_W      = $clog2(PAGE_BYTES + 1);
    localparam logic [16:0] PAGE_LAST = 17'(PAGE_BYTES - 1);
    localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(WORD_COUNT - 1);

    localparam int OW = pbtb_pkg::OUT_W;
    localparam int WB = pbtb_pkg::WORD_BITS;

    // Input field unpacking
    logic          in_op;
    logic          in_other_full;
    logic [11:0]   in_first;
    logic [11:0]   in_last;
    logic [5:0]    in_widx;
    logic [WB-1:0] in_other;

    assign in_op         = s_tuser[0];
    assign in_other_full = s_tuser[1];
    assign in_first      = s_tdata[11:0];
    assign in_last       = s_tdata[23:12];
    assign in_widx       = s_tdata[29:24];
    assign in_other      = s_tdata[93:30];

    // Control state
    pbtb_pkg::state_t state_reg, state_next;
    logic [WORD_AW-1:0] clr_addr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               out_valid_reg;

    // Item being worked on
    logic          op_reg;
    logic          empty_reg;
    logic          first_word_reg;
    logic [5:0]    first_lo_reg;
    logic [5:0]    last_lo_reg;
    logic [5:0]    w_cur_reg;
    logic [5:0]    w_end_reg;
    logic [WB-1:0] merge_word_reg;
    logic [WB-1:0] fresh_reg;
    logic [CNT_W-1:0] acc_reg;

    // Output payload
    logic [OW-1:0] newly_set_reg;
    logic [OW-1:0] total_reg;
    logic          full_reg;

    // Bitmap memory
    logic [WB-1:0]      bitmap_mem [WORD_COUNT];
    logic [WB-1:0]      rdata_reg;
    logic               rd_en;
    logic [WORD_AW-1:0] rd_addr;
    logic               wr_en;
    logic [WORD_AW-1:0] wr_addr;
    logic [WB-1:0]      wr_data;

    logic s_accept;
    logic out_free;
    logic more_words;
    logic load_out;

    assign out_free = !out_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    // Decode an incoming beat: clip the range, find the start word, spot empty items
    logic [11:0]   last_clip;
    logic          mark_empty;
    logic          merge_empty;
    logic          in_empty;
    logic [5:0]    in_w_start;
    logic [5:0]    in_w_end;
    logic [WORD_AW+5:0] start_ext;
    logic [WORD_AW-1:0] start_addr;

    always_comb
    begin
        if (17'(in_last) > PAGE_LAST)
        begin
            last_clip = PAGE_LAST[11:0];
        end
        else
        begin
            last_clip = in_last;
        end
        mark_empty  = in_first > last_clip;
        merge_empty = 17'(in_widx) > 17'(WORD_COUNT - 1);
        in_empty    = (in_op == pbtb_pkg::OP_MERGE) ? merge_empty : mark_empty;
        if (in_empty)
        begin
            in_w_start = 6'd0;
            in_w_end   = 6'd0;
        end
        else if (in_op == pbtb_pkg::OP_MERGE)
        begin
            in_w_start = in_widx;
            in_w_end   = in_widx;
        end
        else
        begin
            in_w_start = in_first[11:6];
            in_w_end   = last_clip[11:6];
        end
        start_ext  = {{WORD_AW{1'b0}}, in_w_start};
        start_addr = start_ext[WORD_AW-1:0];
    end

    // Mask of the word now in the read-modify-write cycle
    logic [WB-1:0]      cur_mask;
    logic [5:0]         lo_sel;
    logic [5:0]         hi_sel;
    logic [WORD_AW+5:0] cur_ext;
    logic [WORD_AW+5:0] nxt_ext;
    logic [5:0]         w_nxt;
    logic [WORD_AW-1:0] cur_addr;
    logic [WORD_AW-1:0] nxt_addr;

    always_comb
    begin
        lo_sel = first_word_reg ? first_lo_reg : 6'd0;
        hi_sel = (w_cur_reg == w_end_reg) ? last_lo_reg : 6'd63;
        if (empty_reg)
        begin
            cur_mask = '0;
        end
        else if (op_reg == pbtb_pkg::OP_MERGE)
        begin
            cur_mask = merge_word_reg;
        end
        else
        begin
            cur_mask = pbtb_pkg::range_mask(lo_sel, hi_sel);
        end
        more_words = !empty_reg && (op_reg == pbtb_pkg::OP_MARK) && (w_cur_reg != w_end_reg);
        w_nxt      = w_cur_reg + 6'd1;
        cur_ext    = {{WORD_AW{1'b0}}, w_cur_reg};
        nxt_ext    = {{WORD_AW{1'b0}}, w_nxt};
        cur_addr   = cur_ext[WORD_AW-1:0];
        nxt_addr   = nxt_ext[WORD_AW-1:0];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pbtb_pkg::ST_CLEAR:
            begin
                if (clr_addr_reg == LAST_WORD)
                begin
                    state_next = pbtb_pkg::ST_IDLE;
                end
            end
            pbtb_pkg::ST_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = pbtb_pkg::ST_RMW;
                end
            end
            pbtb_pkg::ST_RMW:
            begin
                if (!more_words)
                begin
                    state_next = pbtb_pkg::ST_SUM;
                end
            end
            pbtb_pkg::ST_SUM:
            begin
                if (out_free)
                begin
                    state_next = s_accept ? pbtb_pkg::ST_RMW : pbtb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pbtb_pkg::ST_CLEAR;
            end
        endcase
    end

    // Outputs of the state machine: handshake and memory port control
    always_comb
    begin
        s_tready = 1'b0;
        load_out = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = start_addr;
        wr_en    = 1'b0;
        wr_addr  = cur_addr;
        wr_data  = rdata_reg | cur_mask;
        case (state_reg)
            pbtb_pkg::ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_addr_reg;
                wr_data = '0;
            end
            pbtb_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                rd_en    = s_accept;
            end
            pbtb_pkg::ST_RMW:
            begin
                wr_en   = 1'b1;
                rd_en   = more_words;
                rd_addr = nxt_addr;
            end
            pbtb_pkg::ST_SUM:
            begin
                s_tready = out_free;
                load_out = out_free;
                rd_en    = s_accept;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Count closed out for the finished item
    logic [CNT_W-1:0]    added;
    logic [CNT_W-1:0]    count_new;
    logic [CNT_W+OW-1:0] added_ext;
    logic [CNT_W+OW-1:0] count_ext;

    assign added     = acc_reg + CNT_W'(pbtb_pkg::popcount64(fresh_reg));
    assign count_new = count_reg + added;
    assign added_ext = {{OW{1'b0}}, added};
    assign count_ext = {{OW{1'b0}}, count_new};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pbtb_pkg::ST_CLEAR;
            clr_addr_reg  <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == pbtb_pkg::ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + WORD_AW'(1);
            end
            if (load_out)
            begin
                count_reg     <= count_new;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item registers and per-word bookkeeping
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            op_reg         <= in_op;
            empty_reg      <= in_empty;
            first_word_reg <= 1'b1;
            first_lo_reg   <= in_first[5:0];
            last_lo_reg    <= last_clip[5:0];
            w_cur_reg      <= in_w_start;
            w_end_reg      <= in_w_end;
            merge_word_reg <= in_other_full ? {WB{1'b1}} : in_other;
            fresh_reg      <= '0;
            acc_reg        <= '0;
        end
        else if (state_reg == pbtb_pkg::ST_RMW)
        begin
            fresh_reg      <= cur_mask & ~rdata_reg;
            acc_reg        <= acc_reg + CNT_W'(pbtb_pkg::popcount64(fresh_reg));
            w_cur_reg      <= w_nxt;
            first_word_reg <= 1'b0;
        end
        if (load_out)
        begin
            newly_set_reg <= added_ext[OW-1:0];
            total_reg     <= count_ext[OW-1:0];
            full_reg      <= count_new == CNT_W'(PAGE_BYTES);
        end
    end

    // Bitmap memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bitmap_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= bitmap_mem[rd_addr];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, full_reg, total_reg, newly_set_reg};

    // Bits are set at most once, so the count never passes the page size
    `PBTB_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(PAGE_BYTES))
    // No result leaves while the clearing pass runs
    `PBTB_ASSERT_NOW(a_clear_quiet, state_reg == pbtb_pkg::ST_CLEAR, !out_valid_reg)
    // A read issued during a write-back never targets the word being written
    `PBTB_ASSERT_NOW(a_rmw_no_alias, rd_en && wr_en, rd_addr != wr_addr)
    // Closing an item always leaves a result in the output register
    `PBTB_ASSERT_NEXT(a_sum_loads, load_out, out_valid_reg)

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for page_byte_touch_bitmap: stream stimulus, bitmap predictor, checks.
`timescale 1ns / 100ps

module testbench;

    localparam int PAGE_BYTES   = pbtb_pkg::PAGE_BYTES_DEF;
    localparam int PAGE_WORDS   = PAGE_BYTES / pbtb_pkg::WORD_BITS;
    localparam int RANDOM_BEATS = 1800;
    localparam int LIMIT_CYCLES = 600000;

    typedef struct packed {
        pbtb_pkg::op_t op;
        logic [11:0]   first_byte;
        logic [11:0]   last_byte;
        logic [5:0]    word_index;
        logic [63:0]   other_word;
        logic          other_full;
    } touch_beat_t;

    typedef struct packed {
        logic [12:0] newly_set;
        logic [12:0] touched_total;
        logic        page_full;
    } touch_report_t;

    // Shadow bitmap of the page and the reports it predicts, oldest first.
    class touch_scoreboard;
        logic [63:0]   bitmap [PAGE_WORDS];
        int unsigned   touched;
        touch_report_t pending_reports [$];
        int            failures;

        function new();
            foreach (bitmap[i])
            begin
                bitmap[i] = '0;
            end
            touched  = 0;
            failures = 0;
        endfunction

        // OR bits into one word; return how many bits were fresh.
        function int unsigned or_word(int unsigned w, logic [63:0] bits);
            logic [63:0] fresh;
            int unsigned n;
            fresh     = bits & ~bitmap[w];
            bitmap[w] = bitmap[w] | bits;
            n         = 0;
            for (int k = 0; k < 64; k++)
            begin
                n += fresh[k];
            end
            return n;
        endfunction

        function void note_beat(touch_beat_t b);
            int unsigned   added;
            int unsigned   last;
            int unsigned   w0;
            int unsigned   w1;
            int unsigned   lo;
            int unsigned   hi;
            logic [63:0]   mask;
            touch_report_t r;
            added = 0;
            if (touched < PAGE_BYTES)
            begin
                if (b.op == pbtb_pkg::OP_MARK)
                begin
                    last = (b.last_byte >= PAGE_BYTES) ? PAGE_BYTES - 1 : b.last_byte;
                    if (b.first_byte <= last && b.first_byte < PAGE_BYTES)
                    begin
                        w0 = b.first_byte / 64;
                        w1 = last / 64;
                        for (int unsigned w = w0; w <= w1 && w < PAGE_WORDS; w++)
                        begin
                            lo = (w == w0) ? b.first_byte % 64 : 0;
                            hi = (w == w1) ? last % 64 : 63;
                            for (int k = 0; k < 64; k++)
                            begin
                                mask[k] = (k >= lo && k <= hi);
                            end
                            added += or_word(w, mask);
                        end
                    end
                end
                else if (b.word_index < PAGE_WORDS)
                begin
                    added = or_word(b.word_index, b.other_full ? {64{1'b1}} : b.other_word);
                end
                touched += added;
            end
            r.newly_set     = added[12:0];
            r.touched_total = touched[12:0];
            r.page_full     = (touched == PAGE_BYTES);
            pending_reports.push_back(r);
        endfunction

        function void check_result(logic [31:0] d);
            touch_report_t got;
            touch_report_t want;
            got.newly_set     = d[12:0];
            got.touched_total = d[25:13];
            got.page_full     = d[26];
            if (pending_reports.size() == 0)
            begin
                failures++;
                $display("%0t: unexpected beat newly_set %0d touched_total %0d page_full %0d",
                         $time, got.newly_set, got.touched_total, got.page_full);
                return;
            end
            want = pending_reports.pop_front();
            if (got !== want)
            begin
                failures++;
                $display({"%0t: mismatch newly_set exp %0d got %0d, ",
                          "touched_total exp %0d got %0d, page_full exp %0d got %0d"},
                         $time, want.newly_set, got.newly_set, want.touched_total,
                         got.touched_total, want.page_full, got.page_full);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    // Set during a window of the random part: neither side idles then.
    logic        steady   = 1'b0;
    int          cycles   = 0;

    touch_scoreboard board = new();

    page_byte_touch_bitmap #(
        .PAGE_BYTES(PAGE_BYTES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver: stall about a quarter of the cycles outside the steady window.
    initial
    begin
        forever
        begin
            @(negedge clk);
            m_tready <= steady || ($urandom_range(99) >= 25);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            board.check_result(m_tdata);
        end
    end

    function automatic touch_beat_t make_beat(pbtb_pkg::op_t op, int first, int last, int widx,
                                              logic [63:0] word, logic full);
        touch_beat_t b;
        b.op         = op;
        b.first_byte = first[11:0];
        b.last_byte  = last[11:0];
        b.word_index = widx[5:0];
        b.other_word = word;
        b.other_full = full;
        return b;
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // Present one beat, hold it until taken, then record it.
    task automatic send_beat(touch_beat_t b);
        @(negedge clk);
        while (!steady && $urandom_range(99) < 25)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, b.other_word, b.word_index, b.last_byte, b.first_byte};
        s_tuser  <= {b.other_full, b.op};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        board.note_beat(b);
    endtask

    task automatic send_random_beat();
        int          first;
        int          last;
        int          pick;
        logic [63:0] word;
        pick = $urandom_range(99);
        if ($urandom_range(1) == 0)
        begin
            // Mostly short ranges so the page fills slowly; some long, some empty.
            first = $urandom_range(4095);
            if (pick < 80)
            begin
                last = first + $urandom_range(7);
            end
            else if (pick < 92)
            begin
                last = first + $urandom_range(100, 8);
            end
            else
            begin
                last = (first == 0) ? 0 : $urandom_range(first - 1);
            end
            if (last > 4095)
            begin
                last = 4095;
            end
            send_beat(make_beat(pbtb_pkg::OP_MARK, first, last, $urandom_range(63), rand_word(),
                                $urandom_range(1)));
        end
        else
        begin
            // Sparse words mostly, dense ones and whole-word merges now and then.
            if (pick < 88)
            begin
                word = rand_word() & rand_word() & rand_word() & rand_word();
            end
            else
            begin
                word = rand_word();
            end
            send_beat(make_beat(pbtb_pkg::OP_MERGE, $urandom_range(4095), $urandom_range(4095),
                                $urandom_range(63), word, pick >= 98));
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: edges of the page, word boundaries, empty ranges, both merge kinds.
        send_beat(make_beat(pbtb_pkg::OP_MARK, 0, 0, 0, '0, 1'b0));
        send_beat(make_beat(pbtb_pkg::OP_MARK, 4095, 4095, 0, '0, 1'b0));
        send_beat(make_beat(pbtb_pkg::OP_MARK, 100, 50, 0, '0, 1'b0));
        send_beat(make_beat(pbtb_pkg::OP_MARK, 4095, 0, 63, {64{1'b1}}, 1'b1));
        send_beat(make_beat(pbtb_pkg::OP_MARK, 60, 70, 0, '0, 1'b0));
        send_beat(make_beat(pbtb_pkg::OP_MARK, 63, 64, 0, '0, 1'b0));
        send_beat(make_beat(pbtb_pkg::OP_MARK, 0, 63, 0, '0, 1'b0));
        send_beat(make_beat(pbtb_pkg::OP_MARK, 128, 1000, 0, '0, 1'b0));
        send_beat(make_beat(pbtb_pkg::OP_MARK, 3968, 4095, 0, '0, 1'b0));
        send_beat(make_beat(pbtb_pkg::OP_MERGE, 0, 0, 63, 64'h8000_0000_0000_0001, 1'b0));
        send_beat(make_beat(pbtb_pkg::OP_MERGE, 0, 0, 40, '0, 1'b1));
        send_beat(make_beat(pbtb_pkg::OP_MERGE, 0, 0, 30, '0, 1'b0));
        send_beat(make_beat(pbtb_pkg::OP_MERGE, 0, 0, 20, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0));
        send_beat(make_beat(pbtb_pkg::OP_MERGE, 0, 0, 20, 64'h5555_5555_5555_5555, 1'b0));
        send_beat(make_beat(pbtb_pkg::OP_MERGE, 0, 0, 20, {64{1'b1}}, 1'b0));
        send_beat(make_beat(pbtb_pkg::OP_MARK, 2000, 2010, 63, {64{1'b1}}, 1'b1));
        send_beat(make_beat(pbtb_pkg::OP_MERGE, 4095, 0, 25, 64'h1, 1'b0));
        send_beat(make_beat(pbtb_pkg::OP_MERGE, 0, 4095, 26, 64'hFFFF_0000_0000_0000, 1'b0));

        for (int i = 0; i < RANDOM_BEATS; i++)
        begin
            steady = (i >= 700 && i < 1000);
            send_random_beat();
        end
        steady = 1'b0;

        // Fill the page, then confirm that nothing moves once it is full.
        send_beat(make_beat(pbtb_pkg::OP_MARK, 0, 4095, 0, '0, 1'b0));
        for (int i = 0; i < 8; i++)
        begin
            send_random_beat();
        end
        send_beat(make_beat(pbtb_pkg::OP_MERGE, 0, 0, 7, '0, 1'b1));

        @(negedge clk);
        s_tvalid <= 1'b0;

        while (board.pending_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (100) @(posedge clk);

        if (board.failures == 0 && board.pending_reports.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== page_byte_touch_bitmap.f =====
+incdir+sv
sv/pbtb_pkg.sv
sv/page_byte_touch_bitmap.sv
verif/testbench.sv
